// File: sv/i2cm_pkg.sv
package i2cm_pkg;

	localparam logic [1:0] CMD_TICK  = 2'd0;
	localparam logic [1:0] CMD_WRITE = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;

	localparam logic [1:0] STATUS_NONE  = 2'd0;
	localparam logic [1:0] STATUS_BUSY  = 2'd1;
	localparam logic [1:0] STATUS_ERROR = 2'd2;

	localparam logic [7:0] HALF_RESET = 8'd1;
	localparam logic [3:0] BITS_PER_BYTE = 4'd8;

	typedef enum logic [17:0] {
		ST_IDLE   = 18'h00001,
		ST_SA     = 18'h00002,
		ST_SB     = 18'h00004,
		ST_SC     = 18'h00008,
		ST_SD     = 18'h00010,
		ST_TXSET  = 18'h00020,
		ST_TXHI   = 18'h00040,
		ST_TXLO   = 18'h00080,
		ST_ACKREL = 18'h00100,
		ST_ACKHI  = 18'h00200,
		ST_RXHI   = 18'h00400,
		ST_RXLO   = 18'h00800,
		ST_MREL   = 18'h01000,
		ST_MHI    = 18'h02000,
		ST_MLO    = 18'h04000,
		ST_PA     = 18'h08000,
		ST_PB     = 18'h10000,
		ST_PC     = 18'h20000
	} step_t;

	typedef struct packed {
		logic       scl_out;
		logic       sda_release;
		logic       busy_res;
		logic       done_res;
		logic [7:0] read_result;
		logic [1:0] start_status;
		logic [3:0] nack_mask;
	} res_t;

	typedef struct packed {
		logic [1:0] command;
		logic [7:0] device_address;
		logic [7:0] register_address;
		logic [7:0] write_data;
		logic       sda_in;
	} tick_t;

endpackage

// File: sv/i2cm_seq.sv
module i2cm_seq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           step_en,
	input  logic [7:0]     half_period,
	input  i2cm_pkg::tick_t tick,
	output i2cm_pkg::res_t res
);

	i2cm_pkg::step_t step_q, e_step, n_step;
	logic [7:0] phase_q, e_phase, n_phase, pt;
	logic [3:0] bit_q, e_bit, n_bit, bc4;
	logic [2:0] byte_q, e_byte, n_byte;
	logic [7:0] tx_q, n_tx;
	logic [7:0] rx_q, n_rx;
	logic       rmode_q, e_rmode;
	logic [7:0] addr_q, e_addr, reg_q, e_reg, data_q, e_data;
	logic [1:0] status_q, e_status, n_status;
	logic [3:0] nack_q, e_nack, n_nack;
	logic [7:0] last_q, n_last;
	logic       start, done, scl, sda;

	function automatic logic [7:0] load_val(input logic [2:0] bc, input logic rm,
		input logic [7:0] a, input logic [7:0] r, input logic [7:0] d);
		if (bc == 3'd0)
			return a;
		else if (bc == 3'd1)
			return r;
		else
			return rm ? a + 8'd1 : d;
	endfunction

	always_comb begin
		start = (step_q == i2cm_pkg::ST_IDLE) &&
			(tick.command == i2cm_pkg::CMD_WRITE || tick.command == i2cm_pkg::CMD_READ);
		e_step   = start ? i2cm_pkg::ST_SA : step_q;
		e_phase  = start ? 8'd0 : phase_q;
		e_bit    = start ? 4'd0 : bit_q;
		e_byte   = start ? 3'd0 : byte_q;
		e_rmode  = start ? (tick.command == i2cm_pkg::CMD_READ) : rmode_q;
		e_addr   = start ? tick.device_address : addr_q;
		e_reg    = start ? tick.register_address : reg_q;
		e_data   = start ? tick.write_data : data_q;
		e_status = start ? i2cm_pkg::STATUS_NONE : status_q;
		e_nack   = start ? 4'd0 : nack_q;

		// line levels of the phase in force during this tick
		unique case (e_step)
			i2cm_pkg::ST_SA:     begin scl = (e_byte == 3'd0); sda = 1'b1; end
			i2cm_pkg::ST_SC:     begin scl = 1'b1; sda = 1'b0; end
			i2cm_pkg::ST_SD:     begin scl = 1'b0; sda = 1'b0; end
			i2cm_pkg::ST_TXSET:  begin scl = 1'b0; sda = tx_q[7]; end
			i2cm_pkg::ST_TXHI:   begin scl = 1'b1; sda = tx_q[7]; end
			i2cm_pkg::ST_TXLO:   begin scl = 1'b0; sda = tx_q[7]; end
			i2cm_pkg::ST_ACKREL: begin scl = 1'b0; sda = 1'b1; end
			i2cm_pkg::ST_RXLO:   begin scl = 1'b0; sda = 1'b1; end
			i2cm_pkg::ST_MREL:   begin scl = 1'b0; sda = 1'b1; end
			i2cm_pkg::ST_MLO:    begin scl = 1'b0; sda = 1'b1; end
			i2cm_pkg::ST_PA:     begin scl = 1'b0; sda = 1'b0; end
			i2cm_pkg::ST_PB:     begin scl = 1'b1; sda = 1'b0; end
			default:             begin scl = 1'b1; sda = 1'b1; end
		endcase

		n_step   = e_step;
		n_phase  = e_phase;
		n_bit    = e_bit;
		n_byte   = e_byte;
		n_tx     = tx_q;
		n_rx     = rx_q;
		n_status = e_status;
		n_nack   = e_nack;
		n_last   = last_q;
		done     = 1'b0;
		pt       = e_phase + 8'd1;
		bc4      = e_bit + 4'd1;

		if (e_step != i2cm_pkg::ST_IDLE) begin
			n_phase = pt;
			if (pt >= half_period) begin
				n_phase = 8'd0;
				unique case (e_step)
					i2cm_pkg::ST_SA: n_step = i2cm_pkg::ST_SB;
					i2cm_pkg::ST_SB: begin
						if (!tick.sda_in) begin
							if (e_status == i2cm_pkg::STATUS_NONE)
								n_status = i2cm_pkg::STATUS_BUSY;
							n_tx   = load_val(e_byte, e_rmode, e_addr, e_reg, e_data);
							n_bit  = 4'd0;
							n_step = i2cm_pkg::ST_TXSET;
						end else begin
							n_step = i2cm_pkg::ST_SC;
						end
					end
					i2cm_pkg::ST_SC: n_step = i2cm_pkg::ST_SD;
					i2cm_pkg::ST_SD: begin
						if (tick.sda_in && e_status == i2cm_pkg::STATUS_NONE)
							n_status = i2cm_pkg::STATUS_ERROR;
						n_tx   = load_val(e_byte, e_rmode, e_addr, e_reg, e_data);
						n_bit  = 4'd0;
						n_step = i2cm_pkg::ST_TXSET;
					end
					i2cm_pkg::ST_TXSET: n_step = i2cm_pkg::ST_TXHI;
					i2cm_pkg::ST_TXHI:  n_step = i2cm_pkg::ST_TXLO;
					i2cm_pkg::ST_TXLO: begin
						n_tx = {tx_q[6:0], 1'b0};
						if (bc4 >= i2cm_pkg::BITS_PER_BYTE) begin
							n_bit  = 4'd0;
							n_step = i2cm_pkg::ST_ACKREL;
						end else begin
							n_bit  = bc4;
							n_step = i2cm_pkg::ST_TXSET;
						end
					end
					i2cm_pkg::ST_ACKREL: n_step = i2cm_pkg::ST_ACKHI;
					i2cm_pkg::ST_ACKHI: begin
						// no acknowledge: bus stays released high
						if (tick.sda_in) begin
							n_nack = e_nack | (4'd1 << e_byte[1:0]);
							n_nack[3] = 1'b0;
						end
						n_byte = e_byte + 3'd1;
						if (n_byte == 3'd1 || (n_byte == 3'd2 && !e_rmode)) begin
							n_tx   = load_val(n_byte, e_rmode, e_addr, e_reg, e_data);
							n_bit  = 4'd0;
							n_step = i2cm_pkg::ST_TXSET;
						end else if (n_byte == 3'd2) begin
							n_step = i2cm_pkg::ST_SA;
						end else if (e_rmode) begin
							n_rx   = 8'd0;
							n_bit  = 4'd0;
							n_step = i2cm_pkg::ST_RXHI;
						end else begin
							n_step = i2cm_pkg::ST_PA;
						end
					end
					i2cm_pkg::ST_RXHI: begin
						n_rx   = {rx_q[6:0], tick.sda_in};
						n_step = i2cm_pkg::ST_RXLO;
					end
					i2cm_pkg::ST_RXLO: begin
						if (bc4 >= i2cm_pkg::BITS_PER_BYTE) begin
							n_bit  = 4'd0;
							n_step = i2cm_pkg::ST_MREL;
						end else begin
							n_bit  = bc4;
							n_step = i2cm_pkg::ST_RXHI;
						end
					end
					i2cm_pkg::ST_MREL: n_step = i2cm_pkg::ST_MHI;
					i2cm_pkg::ST_MHI:  n_step = i2cm_pkg::ST_MLO;
					i2cm_pkg::ST_MLO:  n_step = i2cm_pkg::ST_PA;
					i2cm_pkg::ST_PA:   n_step = i2cm_pkg::ST_PB;
					i2cm_pkg::ST_PB:   n_step = i2cm_pkg::ST_PC;
					i2cm_pkg::ST_PC: begin
						if (e_rmode)
							n_last = rx_q;
						n_step = i2cm_pkg::ST_IDLE;
						done   = 1'b1;
					end
					default: n_step = i2cm_pkg::ST_IDLE;
				endcase
			end
		end

		res.scl_out      = scl;
		res.sda_release  = sda;
		res.busy_res     = (n_step != i2cm_pkg::ST_IDLE);
		res.done_res     = done;
		res.read_result  = n_last;
		res.start_status = n_status;
		res.nack_mask    = n_nack;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q   <= i2cm_pkg::ST_IDLE;
			phase_q  <= 8'd0;
			bit_q    <= 4'd0;
			byte_q   <= 3'd0;
			tx_q     <= 8'd0;
			rx_q     <= 8'd0;
			rmode_q  <= 1'b0;
			addr_q   <= 8'd0;
			reg_q    <= 8'd0;
			data_q   <= 8'd0;
			status_q <= i2cm_pkg::STATUS_NONE;
			nack_q   <= 4'd0;
			last_q   <= 8'd0;
		end else if (step_en) begin
			step_q   <= n_step;
			phase_q  <= n_phase;
			bit_q    <= n_bit;
			byte_q   <= n_byte;
			tx_q     <= n_tx;
			rx_q     <= n_rx;
			rmode_q  <= e_rmode;
			addr_q   <= e_addr;
			reg_q    <= e_reg;
			data_q   <= e_data;
			status_q <= n_status;
			nack_q   <= n_nack;
			last_q   <= n_last;
		end
	end

endmodule

// File: sv/i2c_master_register_access_unit.sv
// I2C master for single-register write and read transactions, advanced by one
// tick per input transaction. Each tick may carry a command (write or read);
// commands arriving while busy are ignored. Every tick returns one result
// transaction with the SCL/SDA levels of that tick, busy, done, the last read
// byte, start status and the per-byte nack mask. One tick is taken per clock
// unless a full result register is stalled by out_ready; ticks pass through
// the input register, then the sequencer update into the result register.
// half_period_q (reset 1) sets the ticks per line phase; cfg_wr_en writes it.
module i2c_master_register_access_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [7:0] cfg_wr_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] command,
	input  logic [7:0] device_address,
	input  logic [7:0] register_address,
	input  logic [7:0] write_data,
	input  logic       sda_in,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       scl_out,
	output logic       sda_release,
	output logic       busy_res,
	output logic       done_res,
	output logic [7:0] read_result,
	output logic [1:0] start_status,
	output logic [3:0] nack_mask
);

	logic [7:0]      half_period_q;
	logic            valid_s1;
	i2cm_pkg::tick_t tick_s1;
	logic            valid_s2;
	i2cm_pkg::res_t  res, res_s2;
	logic            advance;

	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			half_period_q <= i2cm_pkg::HALF_RESET;
		else if (cfg_wr_en)
			half_period_q <= cfg_wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready)
				valid_s1 <= in_valid;
			if (advance)
				valid_s2 <= 1'b1;
			else if (out_ready)
				valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			tick_s1.command          <= command;
			tick_s1.device_address   <= device_address;
			tick_s1.register_address <= register_address;
			tick_s1.write_data       <= write_data;
			tick_s1.sda_in           <= sda_in;
		end
		if (advance)
			res_s2 <= res;
	end

	i2cm_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.step_en     (advance),
		.half_period (half_period_q),
		.tick        (tick_s1),
		.res         (res)
	);

	assign out_valid    = valid_s2;
	assign scl_out      = res_s2.scl_out;
	assign sda_release  = res_s2.sda_release;
	assign busy_res     = res_s2.busy_res;
	assign done_res     = res_s2.done_res;
	assign read_result  = res_s2.read_result;
	assign start_status = res_s2.start_status;
	assign nack_mask    = res_s2.nack_mask;

`ifndef SYNTHESIS
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> !busy_res)
		else $error("done reported while still busy");

	a_nack_top_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !nack_mask[3])
		else $error("nack bit for a fourth byte set");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> start_status != 2'd3)
		else $error("undefined start status");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(tick_s1))
		else $error("stalled tick lost from input register");
`endif

endmodule

// File: tb/tb.sv
module tb;

	localparam logic [1:0] CMD_SPARE = 2'd3;
	localparam int RANDOM_ITEMS = 100;
	localparam int HOLD_CYCLES = 300;
	localparam int CYCLE_LIMIT = 4000000;

	typedef enum {SDA_SLAVE, SDA_LOW, SDA_HIGH, SDA_NOISE} sda_mode_t;

	logic       clk;
	logic       arst_n;
	logic       cfg_wr_en;
	logic [7:0] cfg_wr_data;
	logic       in_valid;
	logic       in_ready;
	logic [1:0] command;
	logic [7:0] device_address;
	logic [7:0] register_address;
	logic [7:0] write_data;
	logic       sda_in;
	logic       out_valid;
	logic       out_ready;
	logic       scl_out;
	logic       sda_release;
	logic       busy_res;
	logic       done_res;
	logic [7:0] read_result;
	logic [1:0] start_status;
	logic [3:0] nack_mask;

	i2c_master_register_access_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.command(command),
		.device_address(device_address),
		.register_address(register_address),
		.write_data(write_data),
		.sda_in(sda_in),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.scl_out(scl_out),
		.sda_release(sda_release),
		.busy_res(busy_res),
		.done_res(done_res),
		.read_result(read_result),
		.start_status(start_status),
		.nack_mask(nack_mask)
	);

	// sequencer copy used for prediction
	i2cm_pkg::step_t seq_step;
	logic [7:0] half_ticks;
	logic [7:0] phase_cnt;
	logic [3:0] bit_cnt;
	logic [2:0] byte_cnt;
	logic [7:0] tx_sr;
	logic [7:0] rx_sr;
	logic       rd_mode;
	logic [7:0] addr_q;
	logic [7:0] reg_q;
	logic [7:0] data_q;
	logic [1:0] status_q;
	logic [3:0] nack_q;
	logic [7:0] last_rd;

	i2cm_pkg::res_t  bus_results_due[$];
	i2cm_pkg::res_t  want;
	i2cm_pkg::tick_t seen_tick;
	int    mismatches = 0;
	int    items_sent = 0;
	int    cycle_cnt = 0;
	bit    idle_on = 1'b1;
	bit    hold_req = 1'b0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic void clear_model();
		seq_step = i2cm_pkg::ST_IDLE;
		half_ticks = i2cm_pkg::HALF_RESET;
		phase_cnt = '0;
		bit_cnt = '0;
		byte_cnt = '0;
		tx_sr = '0;
		rx_sr = '0;
		rd_mode = 1'b0;
		addr_q = '0;
		reg_q = '0;
		data_q = '0;
		status_q = i2cm_pkg::STATUS_NONE;
		nack_q = '0;
		last_rd = '0;
	endfunction

	function automatic void line_levels(output logic scl, output logic sda);
		logic txb;
		txb = tx_sr[7];
		scl = 1'b1;
		sda = 1'b1;
		case (seq_step)
			i2cm_pkg::ST_SA: scl = (byte_cnt == 3'd0);
			i2cm_pkg::ST_SC: sda = 1'b0;
			i2cm_pkg::ST_SD: begin
				scl = 1'b0;
				sda = 1'b0;
			end
			i2cm_pkg::ST_TXSET, i2cm_pkg::ST_TXLO: begin
				scl = 1'b0;
				sda = txb;
			end
			i2cm_pkg::ST_TXHI: sda = txb;
			i2cm_pkg::ST_ACKREL, i2cm_pkg::ST_RXLO, i2cm_pkg::ST_MREL,
			i2cm_pkg::ST_MLO: scl = 1'b0;
			i2cm_pkg::ST_PA: begin
				scl = 1'b0;
				sda = 1'b0;
			end
			i2cm_pkg::ST_PB: sda = 1'b0;
			default: ;
		endcase
	endfunction

	function automatic void load_byte();
		if (byte_cnt == 3'd0)
			tx_sr = addr_q;
		else if (byte_cnt == 3'd1)
			tx_sr = reg_q;
		else
			tx_sr = rd_mode ? addr_q + 8'd1 : data_q;
		bit_cnt = '0;
		seq_step = i2cm_pkg::ST_TXSET;
	endfunction

	// advance past the end of the current line phase, returns 1 when stop completes
	function automatic logic end_phase(logic sda);
		logic fin;
		fin = 1'b0;
		case (seq_step)
			i2cm_pkg::ST_SA: seq_step = i2cm_pkg::ST_SB;
			i2cm_pkg::ST_SB: begin
				if (!sda) begin
					if (status_q == i2cm_pkg::STATUS_NONE)
						status_q = i2cm_pkg::STATUS_BUSY;
					load_byte();
				end else
					seq_step = i2cm_pkg::ST_SC;
			end
			i2cm_pkg::ST_SC: seq_step = i2cm_pkg::ST_SD;
			i2cm_pkg::ST_SD: begin
				if (sda && status_q == i2cm_pkg::STATUS_NONE)
					status_q = i2cm_pkg::STATUS_ERROR;
				load_byte();
			end
			i2cm_pkg::ST_TXSET: seq_step = i2cm_pkg::ST_TXHI;
			i2cm_pkg::ST_TXHI: seq_step = i2cm_pkg::ST_TXLO;
			i2cm_pkg::ST_TXLO: begin
				tx_sr = tx_sr << 1;
				bit_cnt = bit_cnt + 4'd1;
				if (bit_cnt >= i2cm_pkg::BITS_PER_BYTE) begin
					bit_cnt = '0;
					seq_step = i2cm_pkg::ST_ACKREL;
				end else
					seq_step = i2cm_pkg::ST_TXSET;
			end
			i2cm_pkg::ST_ACKREL: seq_step = i2cm_pkg::ST_ACKHI;
			i2cm_pkg::ST_ACKHI: begin
				if (sda)
					nack_q = (nack_q | (4'd1 << byte_cnt[1:0])) & 4'h7;
				byte_cnt = byte_cnt + 3'd1;
				if (byte_cnt == 3'd1)
					load_byte();
				else if (byte_cnt == 3'd2) begin
					// read goes back for a repeated start
					if (rd_mode)
						seq_step = i2cm_pkg::ST_SA;
					else
						load_byte();
				end else if (rd_mode) begin
					rx_sr = '0;
					bit_cnt = '0;
					seq_step = i2cm_pkg::ST_RXHI;
				end else
					seq_step = i2cm_pkg::ST_PA;
			end
			i2cm_pkg::ST_RXHI: begin
				rx_sr = {rx_sr[6:0], sda};
				seq_step = i2cm_pkg::ST_RXLO;
			end
			i2cm_pkg::ST_RXLO: begin
				bit_cnt = bit_cnt + 4'd1;
				if (bit_cnt >= i2cm_pkg::BITS_PER_BYTE) begin
					bit_cnt = '0;
					seq_step = i2cm_pkg::ST_MREL;
				end else
					seq_step = i2cm_pkg::ST_RXHI;
			end
			i2cm_pkg::ST_MREL: seq_step = i2cm_pkg::ST_MHI;
			i2cm_pkg::ST_MHI: seq_step = i2cm_pkg::ST_MLO;
			i2cm_pkg::ST_MLO: seq_step = i2cm_pkg::ST_PA;
			i2cm_pkg::ST_PA: seq_step = i2cm_pkg::ST_PB;
			i2cm_pkg::ST_PB: seq_step = i2cm_pkg::ST_PC;
			i2cm_pkg::ST_PC: begin
				if (rd_mode)
					last_rd = rx_sr;
				seq_step = i2cm_pkg::ST_IDLE;
				fin = 1'b1;
			end
			default: seq_step = i2cm_pkg::ST_IDLE;
		endcase
		return fin;
	endfunction

	function automatic i2cm_pkg::res_t predict_bus_tick(input i2cm_pkg::tick_t t);
		i2cm_pkg::res_t r;
		logic scl_l;
		logic sda_l;
		logic fin;
		fin = 1'b0;
		if (seq_step == i2cm_pkg::ST_IDLE &&
				(t.command == i2cm_pkg::CMD_WRITE || t.command == i2cm_pkg::CMD_READ)) begin
			addr_q = t.device_address;
			reg_q = t.register_address;
			data_q = t.write_data;
			rd_mode = (t.command == i2cm_pkg::CMD_READ);
			status_q = i2cm_pkg::STATUS_NONE;
			nack_q = '0;
			byte_cnt = '0;
			bit_cnt = '0;
			phase_cnt = '0;
			seq_step = i2cm_pkg::ST_SA;
		end
		line_levels(scl_l, sda_l);
		if (seq_step != i2cm_pkg::ST_IDLE) begin
			phase_cnt = phase_cnt + 8'd1;
			// a zero half period behaves like one
			if (phase_cnt >= half_ticks) begin
				phase_cnt = '0;
				fin = end_phase(t.sda_in);
			end
		end
		r.scl_out = scl_l;
		r.sda_release = sda_l;
		r.busy_res = (seq_step != i2cm_pkg::ST_IDLE);
		r.done_res = fin;
		r.read_result = last_rd;
		r.start_status = status_q;
		r.nack_mask = nack_q;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [7:0] want_v,
			input logic [7:0] got_v);
		if (want_v !== got_v) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch %s: expected %0h, got %0h", name, want_v, got_v);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_model();
			bus_results_due.delete();
		end else begin
			if (cfg_wr_en)
				half_ticks = cfg_wr_data;
			if (in_valid && in_ready) begin
				seen_tick.command = command;
				seen_tick.device_address = device_address;
				seen_tick.register_address = register_address;
				seen_tick.write_data = write_data;
				seen_tick.sda_in = sda_in;
				bus_results_due.push_back(predict_bus_tick(seen_tick));
			end
			if (out_valid && out_ready) begin
				if (bus_results_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: result transaction with nothing predicted");
				end else begin
					want = bus_results_due.pop_front();
					check_field("scl_out", 8'(want.scl_out), 8'(scl_out));
					check_field("sda_release", 8'(want.sda_release), 8'(sda_release));
					check_field("busy_res", 8'(want.busy_res), 8'(busy_res));
					check_field("done_res", 8'(want.done_res), 8'(done_res));
					check_field("read_result", want.read_result, read_result);
					check_field("start_status", 8'(want.start_status), 8'(start_status));
					check_field("nack_mask", 8'(want.nack_mask), 8'(nack_mask));
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [7:0] rand_byte();
		int k;
		k = $urandom_range(0, 9);
		if (k == 0)
			return 8'h00;
		if (k == 1)
			return 8'hFF;
		return 8'($urandom_range(0, 255));
	endfunction

	// receiver side: random stalls, plus a long hold-off on request
	initial begin
		out_ready = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				out_ready <= 1'b1;
			end else if (idle_on && $urandom_range(0, 4) == 0) begin
				out_ready <= 1'b0;
				repeat (pick_gap()) @(negedge clk);
				out_ready <= 1'b1;
			end else
				out_ready <= 1'b1;
		end
	end

	// entered and left at a falling edge, valid stays up for a back-to-back transaction
	task automatic send_tick(input i2cm_pkg::tick_t t);
		int gap;
		gap = (idle_on && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		command <= t.command;
		device_address <= t.device_address;
		register_address <= t.register_address;
		write_data <= t.write_data;
		sda_in <= t.sda_in;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		items_sent++;
		@(negedge clk);
	endtask

	// level the bus shows for the next tick
	function automatic logic bus_level(sda_mode_t mode, logic [7:0] slave_byte, int nack_pct);
		logic scl_l;
		logic sda_l;
		case (mode)
			SDA_LOW: return 1'b0;
			SDA_HIGH: return 1'b1;
			SDA_NOISE: return 1'($urandom_range(0, 1));
			default: begin
				case (seq_step)
					i2cm_pkg::ST_ACKREL, i2cm_pkg::ST_ACKHI:
						return ($urandom_range(1, 100) <= nack_pct);
					i2cm_pkg::ST_RXHI, i2cm_pkg::ST_RXLO:
						return slave_byte[3'd7 - bit_cnt[2:0]];
					default: begin
						line_levels(scl_l, sda_l);
						return sda_l;
					end
				endcase
			end
		endcase
	endfunction

	task automatic run_transfer(input logic [1:0] cmd, input logic [7:0] addr,
			input logic [7:0] reg_a, input logic [7:0] data, input sda_mode_t mode,
			input logic [7:0] slave_byte, input int nack_pct, input bit stray_cmds);
		i2cm_pkg::tick_t t;
		t.command = cmd;
		t.device_address = addr;
		t.register_address = reg_a;
		t.write_data = data;
		t.sda_in = bus_level(mode, slave_byte, nack_pct);
		send_tick(t);
		while (seq_step != i2cm_pkg::ST_IDLE) begin
			// commands arriving mid-transaction must be ignored
			t.command = (stray_cmds && $urandom_range(0, 5) == 0) ?
				2'($urandom_range(0, 3)) : i2cm_pkg::CMD_TICK;
			t.device_address = rand_byte();
			t.register_address = rand_byte();
			t.write_data = rand_byte();
			t.sda_in = bus_level(mode, slave_byte, nack_pct);
			send_tick(t);
		end
	endtask

	task automatic send_idle_tick();
		i2cm_pkg::tick_t t;
		t.command = $urandom_range(0, 1) ? i2cm_pkg::CMD_TICK : CMD_SPARE;
		t.device_address = rand_byte();
		t.register_address = rand_byte();
		t.write_data = rand_byte();
		t.sda_in = 1'($urandom_range(0, 1));
		send_tick(t);
	endtask

	task automatic wait_results();
		in_valid <= 1'b0;
		while (bus_results_due.size() != 0)
			@(negedge clk);
	endtask

	task automatic set_half(input logic [7:0] v);
		wait_results();
		repeat (4) @(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic test_idle_ticks();
		repeat (6) send_idle_tick();
	endtask

	task automatic test_write_transfers();
		set_half(8'd1);
		run_transfer(i2cm_pkg::CMD_WRITE, 8'hFF, 8'h00, 8'hFF, SDA_SLAVE, 8'h00, 0, 1'b0);
		run_transfer(i2cm_pkg::CMD_WRITE, 8'h00, 8'hFF, 8'h00, SDA_SLAVE, 8'h00, 100, 1'b0);
	endtask

	task automatic test_read_transfers();
		run_transfer(i2cm_pkg::CMD_READ, 8'hFF, 8'h5A, 8'h00, SDA_SLAVE, 8'hFF, 0, 1'b0);
		run_transfer(i2cm_pkg::CMD_READ, 8'h00, 8'hA5, 8'hFF, SDA_SLAVE, 8'h00, 100, 1'b0);
		run_transfer(i2cm_pkg::CMD_READ, 8'h7E, 8'h81, 8'h3C, SDA_SLAVE, 8'hA5, 30, 1'b0);
	endtask

	task automatic test_start_faults();
		// held low: bus busy before start; held high: bus error after start
		run_transfer(i2cm_pkg::CMD_WRITE, 8'h42, 8'h10, 8'hC3, SDA_LOW, 8'h00, 0, 1'b0);
		run_transfer(i2cm_pkg::CMD_WRITE, 8'h42, 8'h10, 8'hC3, SDA_HIGH, 8'h00, 0, 1'b0);
		run_transfer(i2cm_pkg::CMD_READ, 8'h43, 8'h20, 8'h00, SDA_HIGH, 8'h00, 0, 1'b0);
		run_transfer(i2cm_pkg::CMD_READ, 8'h91, 8'h6E, 8'h00, SDA_NOISE, 8'h00, 0, 1'b0);
	endtask

	task automatic test_stray_commands();
		run_transfer(i2cm_pkg::CMD_WRITE, 8'h3A, 8'hC5, 8'h96, SDA_SLAVE, 8'h00, 10, 1'b1);
		run_transfer(i2cm_pkg::CMD_READ, 8'hC4, 8'h3B, 8'h69, SDA_SLAVE, 8'h69, 10, 1'b1);
	endtask

	task automatic test_half_period();
		set_half(8'd0);
		run_transfer(i2cm_pkg::CMD_WRITE, 8'h55, 8'hAA, 8'h0F, SDA_SLAVE, 8'h00, 20, 1'b0);
		run_transfer(i2cm_pkg::CMD_READ, 8'hAA, 8'h55, 8'hF0, SDA_SLAVE, 8'hC6, 20, 1'b0);
		set_half(8'd2);
		run_transfer(i2cm_pkg::CMD_READ, 8'h12, 8'h34, 8'h56, SDA_SLAVE, 8'h9D, 20, 1'b1);
		set_half(8'd1);
	endtask

	task automatic test_backpressure();
		idle_on = 1'b0;
		hold_req = 1'b1;
		run_transfer(i2cm_pkg::CMD_WRITE, 8'hB6, 8'h49, 8'hE1, SDA_SLAVE, 8'h00, 0, 1'b0);
		run_transfer(i2cm_pkg::CMD_READ, 8'hB6, 8'h49, 8'h00, SDA_SLAVE, 8'h3E, 0, 1'b0);
		// sender waits until everything has drained
		wait_results();
		idle_on = 1'b1;
		send_idle_tick();
	endtask

	task automatic test_random();
		int stop_at;
		int n;
		int k;
		int pct;
		logic [1:0] cmd;
		logic [7:0] hp;
		sda_mode_t mode;
		stop_at = items_sent + RANDOM_ITEMS;
		n = 0;
		while (items_sent < stop_at) begin
			if (n % 4 == 0) begin
				k = $urandom_range(0, 9);
				if (k == 0)
					hp = 8'd0;
				else if (k < 7)
					hp = 8'd1;
				else if (k == 7)
					hp = 8'd2;
				else if (k == 8)
					hp = 8'd3;
				else
					hp = 8'($urandom_range(4, 8));
				set_half(hp);
			end
			idle_on = ($urandom_range(0, 3) != 0);
			cmd = $urandom_range(0, 1) ? i2cm_pkg::CMD_READ : i2cm_pkg::CMD_WRITE;
			k = $urandom_range(0, 9);
			if (k < 7)
				mode = SDA_SLAVE;
			else if (k == 7)
				mode = SDA_LOW;
			else if (k == 8)
				mode = SDA_HIGH;
			else
				mode = SDA_NOISE;
			k = $urandom_range(0, 2);
			pct = (k == 0) ? 0 : (k == 1) ? 10 : 50;
			run_transfer(cmd, rand_byte(), rand_byte(), rand_byte(), mode, rand_byte(), pct,
				1'($urandom_range(0, 1)));
			repeat ($urandom_range(0, 4)) send_idle_tick();
			n++;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		in_valid = 1'b0;
		command = i2cm_pkg::CMD_TICK;
		device_address = '0;
		register_address = '0;
		write_data = '0;
		sda_in = 1'b1;
		clear_model();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_idle_ticks();
		test_write_transfers();
		test_read_transfers();
		test_start_faults();
		test_stray_commands();
		test_half_period();
		test_backpressure();
		test_random();
		wait_results();
		repeat (10) @(negedge clk);
		if (mismatches == 0 && bus_results_due.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// File: i2c_master_register_access_unit.f
sv/i2cm_pkg.sv
sv/i2cm_seq.sv
sv/i2c_master_register_access_unit.sv
tb/tb.sv
